/* design/circle_collision_time_top_defines.svh */
// Assertion macros used by the circle collision time checker.
// Depends on nothing; the including scope provides clk and arst_n.
`ifndef CIRCLE_COLLISION_TIME_TOP_DEFINES_SVH
`define CIRCLE_COLLISION_TIME_TOP_DEFINES_SVH

// Clocked assertion that is ignored while reset is asserted.
`define CCT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CCT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/cct_pkg.sv */
// Shared types and widths for the circle collision time block.
// Depends on nothing; the front end, back end, top level and checker use it.
package cct_pkg;

	localparam int COORD_BITS    = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int UBITS  = COORD_BITS - 1;
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int AW     = 2 * COORD_BITS + 3;
	localparam int DW     = 2 * AW;
	localparam int SW     = AW;
	localparam int QW     = UBITS;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] pos_a_x;
		logic signed [COORD_BITS-1:0] pos_a_y;
		logic signed [COORD_BITS-1:0] pos_b_x;
		logic signed [COORD_BITS-1:0] pos_b_y;
		logic signed [COORD_BITS-1:0] vel_a_x;
		logic signed [COORD_BITS-1:0] vel_a_y;
		logic signed [COORD_BITS-1:0] vel_b_x;
		logic signed [COORD_BITS-1:0] vel_b_y;
		logic [UBITS-1:0]             radius_a;
		logic [UBITS-1:0]             radius_b;
		logic [UBITS-1:0]             frame_limit;
	} pair_t;

	typedef struct packed {
		logic             will_hit;
		logic [UBITS-1:0] hit_time;
		logic             overlapping;
	} result_t;

	// Classified item handed from the front end to the root and divide pipeline.
	typedef struct packed {
		logic             dead;
		logic             overlap;
		logic [DW-1:0]    d;
		logic [AW-1:0]    h;
		logic [AW-1:0]    a;
		logic [UBITS-1:0] limit;
	} mid_item_t;

endpackage

/* design/cct_mul.sv */
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on nothing.
module cct_mul #(
	parameter int W = 33
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p
);
	localparam int L  = (W + 1) / 2;
	localparam int H  = W - L;
	localparam int PW = 2 * W;

	logic [2*L-1:0] pp_ll_s1;
	logic [L+H-1:0] pp_lh_s1;
	logic [L+H-1:0] pp_hl_s1;
	logic [2*H-1:0] pp_hh_s1;
	logic [PW-1:0]  p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pp_ll_s1 <= a[L-1:0] * b[L-1:0];
			pp_lh_s1 <= (L+H)'(a[L-1:0]) * (L+H)'(b[W-1:L]);
			pp_hl_s1 <= (L+H)'(a[W-1:L]) * (L+H)'(b[L-1:0]);
			pp_hh_s1 <= a[W-1:L] * b[W-1:L];
			p_s2 <= PW'(pp_ll_s1) + (PW'(pp_lh_s1) << L) + (PW'(pp_hl_s1) << L)
				+ (PW'(pp_hh_s1) << (2 * L));
		end
	end

	assign p = p_s2;
endmodule

/* design/cct_fifo.sv */
// Small first-in first-out queue with valid/ready on both sides.
// Depends on nothing.
module cct_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);
	localparam int PW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = count_q != (PW+1)'(DEPTH);
	assign rd_valid = count_q != '0;
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (!do_wr && do_rd) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end
endmodule

/* design/cct_front.sv */
// Front end: relative motion, quadratic terms, discriminant and no-hit classification.
// Depends on cct_pkg and cct_mul.
module cct_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cct_pkg::pair_t     in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cct_pkg::mid_item_t out_item
);
	import cct_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic [DIFF_W-1:0] xx_w, xy_w, vx_w, vy_w;
	logic [DIFF_W-1:0] ux_s1, uy_s1, wx_s1, wy_s1;
	logic              negx_s1, negy_s1, negx_s2, negy_s2, negx_s3, negy_s3;
	logic [COORD_BITS-1:0] rsum_s1;
	logic [UBITS-1:0]  lim_s1, lim_s2, lim_s3, lim_s4, lim_s5, lim_s6, lim_s7;

	logic [SQ_W-1:0] pxx_w, pyy_w, pvx_w, pvy_w, ppx_w, ppy_w, prr_w;

	logic [AW-1:0] dist2_s4, r2_s4, a_s4, pos_s4, neg_s4;
	logic [AW-1:0] h_s5, a_s5, c_s5, h_s6, a_s6, h_s7, a_s7;
	logic          ovl_s5, ovl_s6, ovl_s7, nohit_s5, nohit_s6, nohit_s7;
	logic [DW-1:0] hh_w, ac_w;
	logic [DW:0]   disc_w;
	mid_item_t     item_s8;

	assign en       = !v_s8 || out_ready;
	assign in_ready = en;

	// Relative offset and velocity, each a sign and a magnitude.
	always_comb begin
		xx_w = {in_item.pos_a_x[COORD_BITS-1], in_item.pos_a_x}
			- {in_item.pos_b_x[COORD_BITS-1], in_item.pos_b_x};
		xy_w = {in_item.pos_a_y[COORD_BITS-1], in_item.pos_a_y}
			- {in_item.pos_b_y[COORD_BITS-1], in_item.pos_b_y};
		vx_w = {in_item.vel_a_x[COORD_BITS-1], in_item.vel_a_x}
			- {in_item.vel_b_x[COORD_BITS-1], in_item.vel_b_x};
		vy_w = {in_item.vel_a_y[COORD_BITS-1], in_item.vel_a_y}
			- {in_item.vel_b_y[COORD_BITS-1], in_item.vel_b_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1   <= xx_w[DIFF_W-1] ? (~xx_w) + DIFF_W'(1) : xx_w;
			uy_s1   <= xy_w[DIFF_W-1] ? (~xy_w) + DIFF_W'(1) : xy_w;
			wx_s1   <= vx_w[DIFF_W-1] ? (~vx_w) + DIFF_W'(1) : vx_w;
			wy_s1   <= vy_w[DIFF_W-1] ? (~vy_w) + DIFF_W'(1) : vy_w;
			negx_s1 <= xx_w[DIFF_W-1] ^ vx_w[DIFF_W-1];
			negy_s1 <= xy_w[DIFF_W-1] ^ vy_w[DIFF_W-1];
			rsum_s1 <= {1'b0, in_item.radius_a} + {1'b0, in_item.radius_b};
			lim_s1  <= in_item.frame_limit;

			negx_s2 <= negx_s1; negy_s2 <= negy_s1; lim_s2 <= lim_s1;
			negx_s3 <= negx_s2; negy_s3 <= negy_s2; lim_s3 <= lim_s2;

			dist2_s4 <= {1'b0, pxx_w} + {1'b0, pyy_w};
			a_s4     <= {1'b0, pvx_w} + {1'b0, pvy_w};
			r2_s4    <= {1'b0, prr_w};
			pos_s4   <= (negx_s3 ? AW'(0) : AW'(ppx_w)) + (negy_s3 ? AW'(0) : AW'(ppy_w));
			neg_s4   <= (negx_s3 ? AW'(ppx_w) : AW'(0)) + (negy_s3 ? AW'(ppy_w) : AW'(0));
			lim_s4   <= lim_s3;

			// The early root is positive only while closing in and not yet touching.
			ovl_s5   <= dist2_s4 < r2_s4;
			nohit_s5 <= (dist2_s4 <= r2_s4) || (a_s4 == '0) || (neg_s4 <= pos_s4);
			h_s5     <= neg_s4 - pos_s4;
			c_s5     <= dist2_s4 - r2_s4;
			a_s5     <= a_s4;
			lim_s5   <= lim_s4;

			h_s6 <= h_s5; a_s6 <= a_s5; ovl_s6 <= ovl_s5; nohit_s6 <= nohit_s5; lim_s6 <= lim_s5;
			h_s7 <= h_s6; a_s7 <= a_s6; ovl_s7 <= ovl_s6; nohit_s7 <= nohit_s6; lim_s7 <= lim_s6;

			item_s8.dead    <= nohit_s7 || disc_w[DW] || (disc_w[DW-1:0] == '0);
			item_s8.overlap <= ovl_s7;
			item_s8.d       <= disc_w[DW-1:0];
			item_s8.h       <= h_s7;
			item_s8.a       <= a_s7;
			item_s8.limit   <= lim_s7;
		end
	end

	cct_mul #(.W(DIFF_W)) u_mul_xx (.clk, .en, .a(ux_s1), .b(ux_s1), .p(pxx_w));
	cct_mul #(.W(DIFF_W)) u_mul_yy (.clk, .en, .a(uy_s1), .b(uy_s1), .p(pyy_w));
	cct_mul #(.W(DIFF_W)) u_mul_vx (.clk, .en, .a(wx_s1), .b(wx_s1), .p(pvx_w));
	cct_mul #(.W(DIFF_W)) u_mul_vy (.clk, .en, .a(wy_s1), .b(wy_s1), .p(pvy_w));
	cct_mul #(.W(DIFF_W)) u_mul_px (.clk, .en, .a(ux_s1), .b(wx_s1), .p(ppx_w));
	cct_mul #(.W(DIFF_W)) u_mul_py (.clk, .en, .a(uy_s1), .b(wy_s1), .p(ppy_w));
	cct_mul #(.W(DIFF_W)) u_mul_rr (.clk, .en, .a({1'b0, rsum_s1}), .b({1'b0, rsum_s1}),
		.p(prr_w));

	cct_mul #(.W(AW)) u_mul_hh (.clk, .en, .a(h_s5), .b(h_s5), .p(hh_w));
	cct_mul #(.W(AW)) u_mul_ac (.clk, .en, .a(a_s5), .b(c_s5), .p(ac_w));

	assign disc_w    = {1'b0, hh_w} - {1'b0, ac_w};
	assign out_valid = v_s8;
	assign out_item  = item_s8;
endmodule

/* design/cct_back.sv */
// Back end: pipelined integer square root, restoring divide, rounding and limit check.
// Depends on cct_pkg.
module cct_back #(
	parameter int FRAC_BITS = cct_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cct_pkg::mid_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cct_pkg::result_t   out_item
);
	import cct_pkg::*;

	localparam int RW = SW + 2;
	localparam int NW = AW + FRAC_BITS;
	localparam int XW = (NW > AW + QW) ? NW : AW + QW;
	localparam int NP = SW + QW + 1;

	logic          en;
	logic          vld_q [NP+1];
	mid_item_t     pay_q [NP];
	mid_item_t     pay_n [NP];
	logic [RW-1:0] rem_q [SW];
	logic [SW-1:0] root_q [SW];
	logic [RW+SW-1:0] sstep_w [SW];
	logic [AW:0]   drem_q [QW+1];
	logic [AW:0]   drem_n [QW+1];
	logic [QW-1:0] nb_q [QW+1];
	logic [QW-1:0] nb_n [QW+1];
	logic [QW-1:0] quo_q [QW+1];
	logic [QW-1:0] quo_n [QW+1];
	logic [AW+1:0] dstep_w [QW];
	logic [NW-1:0] num_w;
	logic          sat_w;
	logic [QW:0]   qc_w;
	logic          hit_w;
	result_t       res_n;
	result_t       res_q;

	// One result bit of the root: bring down two bits of the radicand.
	function automatic logic [RW+SW-1:0] sqrt_step(input logic [RW-1:0] rem,
		input logic [SW-1:0] root, input logic [1:0] bits);
		logic [RW-1:0] sh;
		logic [RW-1:0] trial;
		sh    = {rem[RW-3:0], bits};
		trial = {root, 2'b01};
		if (sh >= trial) begin
			return {sh - trial, root[SW-2:0], 1'b1};
		end
		return {sh, root[SW-2:0], 1'b0};
	endfunction

	// One quotient bit; rem stays below den.
	function automatic logic [AW+1:0] div_step(input logic [AW:0] rem, input logic bitin,
		input logic [AW-1:0] den);
		logic [AW:0] sh;
		sh = {rem[AW-1:0], bitin};
		if (sh >= {1'b0, den}) begin
			return {sh - {1'b0, den}, 1'b1};
		end
		return {sh, 1'b0};
	endfunction

	assign en       = !vld_q[NP] || out_ready;
	assign in_ready = en;

	always_comb begin
		sstep_w[0] = sqrt_step('0, '0, in_item.d[DW-1 -: 2]);
		pay_n[0]   = in_item;
		pay_n[0].d = in_item.d << 2;
		for (int k = 1; k < SW; k++) begin
			sstep_w[k] = sqrt_step(rem_q[k-1], root_q[k-1], pay_q[k-1].d[DW-1 -: 2]);
			pay_n[k]   = pay_q[k-1];
			pay_n[k].d = pay_q[k-1].d << 2;
		end

		// h exceeds the root here, so the numerator is never negative.
		num_w = NW'(pay_q[SW-1].h - root_q[SW-1]) << FRAC_BITS;
		sat_w = XW'(num_w) >= (XW'(pay_q[SW-1].a) << QW);
		pay_n[SW]      = pay_q[SW-1];
		pay_n[SW].dead = pay_q[SW-1].dead || sat_w;
		drem_n[0] = (AW+1)'(num_w >> QW);
		nb_n[0]   = num_w[QW-1:0];
		quo_n[0]  = '0;

		for (int j = 1; j <= QW; j++) begin
			dstep_w[j-1] = div_step(drem_q[j-1], nb_q[j-1][QW-1], pay_q[SW+j-1].a);
			drem_n[j]    = dstep_w[j-1][AW+1:1];
			quo_n[j]     = {quo_q[j-1][QW-2:0], dstep_w[j-1][0]};
			nb_n[j]      = nb_q[j-1] << 1;
			pay_n[SW+j]  = pay_q[SW+j-1];
		end

		// Round the quotient up when the divide leaves a remainder.
		qc_w  = {1'b0, quo_q[QW]} + (QW+1)'(drem_q[QW] != '0);
		hit_w = !pay_q[NP-1].dead && (qc_w <= {1'b0, pay_q[NP-1].limit});
		res_n.will_hit    = hit_w;
		res_n.hit_time    = hit_w ? qc_w[QW-1:0] : '0;
		res_n.overlapping = pay_q[NP-1].overlap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NP; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i <= NP; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NP; i++) begin
				pay_q[i] <= pay_n[i];
			end
			for (int k = 0; k < SW; k++) begin
				rem_q[k]  <= sstep_w[k][RW+SW-1:SW];
				root_q[k] <= sstep_w[k][SW-1:0];
			end
			for (int j = 0; j <= QW; j++) begin
				drem_q[j] <= drem_n[j];
				nb_q[j]   <= nb_n[j];
				quo_q[j]  <= quo_n[j];
			end
			res_q <= res_n;
		end
	end

	assign out_valid = vld_q[NP];
	assign out_item  = res_q;
endmodule

/* design/circle_collision_time_top.sv */
// Swept circle collision time. One pair of moving circles enters per clock cycle while full
// is low, and results leave in order, one per pair. On the way from the pair ports to the
// result ports, eight front-end stages form the quadratic and its discriminant, the middle
// queue holds the classified item, the pipelined square root takes one stage per root bit
// (2*COORD_BITS + 3), one stage sets up the divide, the divider takes one stage per time bit,
// one stage rounds and checks the limit, and the result queue holds the result. A queue sits
// between the front end and the root and divide pipeline and another in front of the result
// ports, so each side stalls on its own without losing items. Reset clears only control state.
module circle_collision_time_top #(
	parameter int FRAC_BITS   = cct_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = cct_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  cct_pkg::pair_t   pair,
	output logic             empty,
	input  logic             pop,
	output cct_pkg::result_t result
);
	import cct_pkg::*;

	logic      fe_ready, fe_valid, mq_ready, mq_valid, be_ready, be_valid, rq_ready, rq_valid;
	mid_item_t fe_item, mq_item;
	result_t   be_item;

	assign full  = !fe_ready;
	assign empty = !rq_valid;

	cct_front u_front (
		.clk, .arst_n,
		.in_valid(push), .in_ready(fe_ready), .in_item(pair),
		.out_valid(fe_valid), .out_ready(mq_ready), .out_item(fe_item)
	);

	cct_fifo #(.W($bits(mid_item_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
		.clk, .arst_n,
		.wr_valid(fe_valid), .wr_ready(mq_ready), .wr_data(fe_item),
		.rd_valid(mq_valid), .rd_ready(be_ready), .rd_data(mq_item)
	);

	cct_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.in_valid(mq_valid), .in_ready(be_ready), .in_item(mq_item),
		.out_valid(be_valid), .out_ready(rq_ready), .out_item(be_item)
	);

	cct_fifo #(.W($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
		.clk, .arst_n,
		.wr_valid(be_valid), .wr_ready(rq_ready), .wr_data(be_item),
		.rd_valid(rq_valid), .rd_ready(pop), .rd_data(result)
	);
endmodule

/* design/cct_check.sv */
// Port-level checks for the circle collision time block, bound to the top level.
// Depends on cct_pkg and circle_collision_time_top_defines.svh.
`include "circle_collision_time_top_defines.svh"

module cct_check (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input cct_pkg::pair_t   pair,
	input logic             empty,
	input logic             pop,
	input cct_pkg::result_t result
);
	`CCT_ASSERT(a_hit_not_overlap, !empty && result.will_hit |-> !result.overlapping, "hit reported on overlapping circles")
	`CCT_ASSERT(a_miss_zero_time, !empty && !result.will_hit |-> result.hit_time == '0, "nonzero time without a hit")
	`CCT_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(result), "waiting result changed")
endmodule

bind circle_collision_time_top cct_check u_cct_check (.*);
